// ----- rtl/jccs_pkg.sv -----
// jccs_pkg: types, character constants and escape helpers for the json control
// character sanitizer
// no dependencies
package jccs_pkg;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_HT = 8'h09;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_CR = 8'h0D;

    localparam int unsigned IDX_W = 3;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SHORT,
        KIND_UNI
    } t_kind;

    // one input byte after classification, as handed to the expander
    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
        logic       eot;
    } t_desc;

    function automatic logic [7:0] nibble_hex(input logic [3:0] v);
        logic [3:0] m;
        m = v & NIBBLE_MASK;
        if (m < 4'd10) begin
            return CHAR_ZERO + {4'd0, m};
        end else begin
            return CHAR_A + {4'd0, m} - 8'd10;
        end
    endfunction

    function automatic logic is_short(input logic [7:0] ch);
        return (ch == CTRL_BS) || (ch == CTRL_HT) || (ch == CTRL_LF) ||
               (ch == CTRL_FF) || (ch == CTRL_CR);
    endfunction

    function automatic logic [7:0] short_letter(input logic [7:0] ch);
        logic [7:0] l;
        case (ch)
            CTRL_BS: l = 8'h62; // b
            CTRL_FF: l = 8'h66; // f
            CTRL_LF: l = 8'h6E; // n
            CTRL_CR: l = 8'h72; // r
            CTRL_HT: l = 8'h74; // t
            default: l = CHAR_U;
        endcase
        return l;
    endfunction

    function automatic logic [IDX_W-1:0] seq_len(input t_kind kind);
        logic [IDX_W-1:0] n;
        case (kind)
            KIND_PASS:  n = 3'd1;
            KIND_SHORT: n = 3'd2;
            KIND_UNI:   n = 3'd6;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input t_desc d, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (d.kind)
            KIND_PASS:  b = d.ch;
            KIND_SHORT: b = (idx == 3'd0) ? CHAR_BSLASH : short_letter(d.ch);
            KIND_UNI: begin
                case (idx)
                    3'd0:    b = CHAR_BSLASH;
                    3'd1:    b = CHAR_U;
                    3'd2:    b = CHAR_ZERO;
                    3'd3:    b = CHAR_ZERO;
                    3'd4:    b = nibble_hex(d.ch[7:4]);
                    3'd5:    b = nibble_hex(d.ch[3:0]);
                    default: b = CHAR_BSLASH;
                endcase
            end
            default:    b = d.ch;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/json_control_char_sanitizer.sv -----
// json_control_char_sanitizer: top level, escapes raw control bytes inside
// json string literals; depends on jccs_pkg, jccs_track, jccs_expand
//
// The block takes serialized json text one byte per input transaction and
// gives the sanitized text one byte per output transaction. Inside a string
// literal an unescaped byte below 0x20 is rewritten: backspace, form feed,
// newline, return and tab become two-byte short escapes, every other control
// byte becomes the six-byte \u00xy form with lower-case hex. All other bytes,
// quotes and escaped bytes included, pass through unchanged. last_of_run
// marks the final output byte of each input byte; text_done marks that byte
// for the input carrying end_of_text, after which the string and escape
// flags are cleared. Plain text flows at one byte per cycle while the
// consumer keeps i_out_ready high; an escaped byte occupies the expander
// until all two or six of its output bytes have moved to the output
// register, and input is held off meanwhile. A byte passes through the
// holding register, then the output register, and the output register lets
// a new byte be accepted while a finished one waits for the consumer.
module json_control_char_sanitizer
    import jccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_text_done
);

    logic  w_free;
    logic  w_accept;
    t_desc w_desc;

    // input is taken whenever the holding register is empty or empties now
    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    // flag tracking and classification happen at the input transaction
    jccs_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_desc        (w_desc)
    );

    // sequence expansion into the registered output
    jccs_expand u_expand (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_desc        (w_desc),
        .o_free        (w_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

endmodule

// ----- rtl/jccs_track.sv -----
// jccs_track: string and escape flags, classifies each accepted byte
// depends on jccs_pkg
module jccs_track
    import jccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output t_desc      o_desc
);

    logic r_inside;
    logic r_after_bs;
    logic n_inside;
    logic n_after_bs;
    t_kind w_kind;

    always_comb begin
        n_inside   = r_inside;
        n_after_bs = r_after_bs;
        w_kind     = KIND_PASS;
        if (!r_inside) begin
            if (i_in_byte == CHAR_QUOTE) begin
                n_inside = 1'b1;
            end
        end else if (r_after_bs) begin
            n_after_bs = 1'b0;
        end else if (i_in_byte == CHAR_BSLASH) begin
            n_after_bs = 1'b1;
        end else if (i_in_byte == CHAR_QUOTE) begin
            n_inside = 1'b0;
        end else if (i_in_byte < CTRL_LIMIT) begin
            w_kind = is_short(i_in_byte) ? KIND_SHORT : KIND_UNI;
        end
        // end of text drops both flags
        if (i_end_of_text) begin
            n_inside   = 1'b0;
            n_after_bs = 1'b0;
        end
    end

    assign o_desc = '{ch: i_in_byte, kind: w_kind, eot: i_end_of_text};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside   <= 1'b0;
            r_after_bs <= 1'b0;
        end else if (i_accept) begin
            r_inside   <= n_inside;
            r_after_bs <= n_after_bs;
        end
    end

endmodule

// ----- rtl/jccs_expand.sv -----
// jccs_expand: holds one classified byte and walks its escape sequence into
// the output register, one byte per transaction; depends on jccs_pkg
module jccs_expand
    import jccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_desc      i_desc,
    output logic       o_free,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_text_done
);

    t_desc            r_desc;
    logic             r_d_valid;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_done;
    logic             r_out_valid;

    logic [IDX_W-1:0] n_idx;
    logic             n_d_valid;
    logic             w_take;
    logic             w_move;
    logic             w_last;

    assign w_take = !r_out_valid || i_out_ready;
    assign w_move = r_d_valid && w_take;
    assign w_last = (r_idx == seq_len(r_desc.kind) - 3'd1);
    assign o_free = !r_d_valid || (w_move && w_last);

    always_comb begin
        n_idx     = r_idx;
        n_d_valid = r_d_valid;
        if (w_move) begin
            if (w_last) begin
                n_idx     = '0;
                n_d_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (i_load) begin
            n_d_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_valid <= n_d_valid;
            r_idx     <= n_idx;
            if (w_take) begin
                r_out_valid <= w_move;
            end
        end
        if (i_load) begin
            r_desc <= i_desc;
        end
        if (w_move) begin
            r_out_byte <= seq_byte(r_desc, r_idx);
            r_out_last <= w_last;
            r_out_done <= w_last && r_desc.eot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_text_done   = r_out_done;

    // a load only lands in a free holding register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("load while holding register busy");

    // index stays inside the current sequence
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> (r_idx < seq_len(r_desc.kind)))
        else $error("sequence index out of range");

    // a partial run on the output always has its remainder still held
    a_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_d_valid)
        else $error("escape run lost its remainder");

    // text end only ever marks the final byte of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("text end on a non-final byte");

endmodule
